FILE: sv/html_entity_encoder_unit_assert.svh
// ----------------------------------------------------------------------------
// html_entity_encoder_unit_assert.svh
// Assertion macros shared by the entity encoder verification files.
// ----------------------------------------------------------------------------
`ifndef HTML_ENTITY_ENCODER_UNIT_ASSERT_SVH
`define HTML_ENTITY_ENCODER_UNIT_ASSERT_SVH

// implication in the same cycle
`define HEE_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// implication in the next cycle
`define HEE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: sv/hee_pkg.sv
// ----------------------------------------------------------------------------
// hee_pkg
// Types and constants of the HTML entity encoder pipeline.
// ----------------------------------------------------------------------------
package hee_pkg;

	localparam int CP_W       = 21;
	localparam int NUM_DIGITS = 7;
	localparam int MAX_BYTES  = 10;
	localparam int LEN_W      = 4;

	// floor(x / 10) == (x * DIV10_MUL) >> DIV10_SHIFT for x < 2**22
	localparam logic [19:0] DIV10_MUL   = 20'hCCCCD;
	localparam int          DIV10_SHIFT = 23;

	localparam logic [CP_W-1:0] ASCII_MAX = 21'd127;

	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_QUOT = 8'h22;
	localparam logic [7:0] CH_LT   = 8'h3C;
	localparam logic [7:0] CH_GT   = 8'h3E;

	localparam logic REG_ESCAPE_QUOTE = 1'b0;
	localparam logic REG_ESCAPE_TAGS  = 1'b1;

	typedef enum logic [2:0] {
		KIND_PLAIN,
		KIND_NUM,
		KIND_QUOT,
		KIND_LT,
		KIND_GT,
		KIND_AMP
	} kind_t;

	typedef struct packed {
		kind_t                      kind;
		logic [2:0]                 num_digits;
		logic [7:0]                 ch;
		logic [CP_W-1:0]            value;
		logic [NUM_DIGITS-1:0][3:0] digits;
	} item_t;

	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [LEN_W-1:0]          len;
	} text_t;

endpackage

FILE: sv/hee_digit.sv
// ----------------------------------------------------------------------------
// hee_digit
// One pipeline stage of the decimal conversion: splits off one digit.
// ----------------------------------------------------------------------------
module hee_digit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  logic           in_valid,
	input  hee_pkg::item_t in_item,
	output logic           out_valid,
	output hee_pkg::item_t out_item
);

	logic [40:0]                quot_prod;
	logic [hee_pkg::CP_W-1:0]   quot;
	logic [hee_pkg::CP_W-1:0]   rem_full;
	hee_pkg::item_t             next_item;
	logic                       valid_q;
	hee_pkg::item_t             item_q;

	always_comb begin
		quot_prod = 41'(in_item.value) * 41'(hee_pkg::DIV10_MUL);
		quot      = hee_pkg::CP_W'(quot_prod >> hee_pkg::DIV10_SHIFT);
		rem_full  = in_item.value - ((quot << 3) + (quot << 1));
		next_item        = in_item;
		next_item.value  = quot;
		next_item.digits = {rem_full[3:0], in_item.digits[hee_pkg::NUM_DIGITS-1:1]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= next_item;
		end
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

endmodule

FILE: sv/hee_format.sv
// ----------------------------------------------------------------------------
// hee_format
// Builds the escaped byte string of one character and registers it.
// ----------------------------------------------------------------------------
module hee_format (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  logic           in_valid,
	input  hee_pkg::item_t in_item,
	output logic           out_valid,
	output hee_pkg::text_t out_text
);

	hee_pkg::text_t next_text;
	logic           valid_q;
	hee_pkg::text_t text_q;

	always_comb begin
		logic [2:0] idx;
		idx       = '0;
		next_text = '0;
		case (in_item.kind)
			hee_pkg::KIND_NUM: begin
				next_text.bytes[0] = hee_pkg::CH_AMP;
				next_text.bytes[1] = hee_pkg::CH_HASH;
				for (int j = 0; j < hee_pkg::MAX_BYTES - 2; j++) begin
					idx = in_item.num_digits - 3'(j) - 3'd1;
					if (4'(j) < {1'b0, in_item.num_digits}) begin
						next_text.bytes[2+j] = hee_pkg::CH_ZERO | {4'b0, in_item.digits[idx]};
					end else if (4'(j) == {1'b0, in_item.num_digits}) begin
						next_text.bytes[2+j] = hee_pkg::CH_SEMI;
					end
				end
				next_text.len = {1'b0, in_item.num_digits} + 4'd3;
			end
			hee_pkg::KIND_QUOT: begin
				next_text.bytes[0] = hee_pkg::CH_AMP;
				next_text.bytes[1] = "q";
				next_text.bytes[2] = "u";
				next_text.bytes[3] = "o";
				next_text.bytes[4] = "t";
				next_text.bytes[5] = hee_pkg::CH_SEMI;
				next_text.len      = 4'd6;
			end
			hee_pkg::KIND_LT: begin
				next_text.bytes[0] = hee_pkg::CH_AMP;
				next_text.bytes[1] = "l";
				next_text.bytes[2] = "t";
				next_text.bytes[3] = hee_pkg::CH_SEMI;
				next_text.len      = 4'd4;
			end
			hee_pkg::KIND_GT: begin
				next_text.bytes[0] = hee_pkg::CH_AMP;
				next_text.bytes[1] = "g";
				next_text.bytes[2] = "t";
				next_text.bytes[3] = hee_pkg::CH_SEMI;
				next_text.len      = 4'd4;
			end
			hee_pkg::KIND_AMP: begin
				next_text.bytes[0] = hee_pkg::CH_AMP;
				next_text.bytes[1] = "a";
				next_text.bytes[2] = "m";
				next_text.bytes[3] = "p";
				next_text.bytes[4] = hee_pkg::CH_SEMI;
				next_text.len      = 4'd5;
			end
			default: begin
				next_text.bytes[0] = in_item.ch;
				next_text.len      = 4'd1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			text_q <= next_text;
		end
	end

	assign out_valid = valid_q;
	assign out_text  = text_q;

endmodule

FILE: sv/hee_emitter.sv
// ----------------------------------------------------------------------------
// hee_emitter
// Output register: sends the bytes of one string, one per request.
// ----------------------------------------------------------------------------
module hee_emitter (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  hee_pkg::text_t in_text,
	output logic           take,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [7:0]     m_tdata,
	output logic           m_tlast
);

	logic                      valid_q;
	logic [hee_pkg::MAX_BYTES-1:0][7:0] bytes_q;
	logic [hee_pkg::LEN_W-1:0] len_q;
	logic [hee_pkg::LEN_W-1:0] pos_q;
	logic                      last;

	assign last = (pos_q == len_q - 4'd1);
	assign take = !valid_q || (m_tready && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pos_q   <= '0;
		end else if (take) begin
			valid_q <= in_valid;
			pos_q   <= '0;
		end else if (m_tready) begin
			pos_q <= pos_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			bytes_q <= in_text.bytes;
			len_q   <= in_text.len;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = bytes_q[pos_q];
	assign m_tlast  = last;

endmodule

FILE: sv/html_entity_encoder_unit.sv
// ----------------------------------------------------------------------------
// html_entity_encoder_unit
// HTML escaping of a stream of Unicode code points into a byte stream.
// ----------------------------------------------------------------------------
// Input stream: one 21-bit code point per request on s_tdata[20:0].
// Output stream: the escaped bytes on m_tdata, m_tlast on the final byte of
// each character. Code points above 127 become "&#N;", '&' becomes "&amp;",
// '"' "&quot;" (escape_quote) and '<' '>' "&lt;" "&gt;" (escape_tags); other
// ASCII passes as one byte.
// Configuration: cfg_we/cfg_index/cfg_data, index 0 escape_quote, index 1
// escape_tags, both 1 after reset. Write only while the block is idle.
// Pipeline: ten register stages (classify, seven digit stages, format,
// output register), the first loaded at the edge that accepts the input
// request. Throughput: one character enters per cycle while each produces
// one byte and m_tready is high; a character of n bytes holds the output
// register until its n bytes are taken, and the pipeline behind it stalls
// stage by stage, filling bubbles first.
// Reset clears all stage valid bits; the output shows nothing until data
// arrives. A stall on m_tready holds the current byte and backs up the
// pipeline until s_tready falls; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module html_entity_encoder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // [20:0] code_point, [23:21] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [7:0] out_byte
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic        cfg_data
);

	localparam int ND = hee_pkg::NUM_DIGITS;

	logic                      escape_quote_q;
	logic                      escape_tags_q;
	logic [hee_pkg::CP_W-1:0]  cp;
	hee_pkg::item_t            cls_item;
	logic                      valid_s1;
	hee_pkg::item_t            item_s1;
	logic [ND:0]               dig_valid;
	hee_pkg::item_t            dig_item [ND+1];
	logic [ND:0]               dig_load;
	logic                      fmt_valid;
	hee_pkg::text_t            fmt_text;
	logic                      fmt_load;
	logic                      emit_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			escape_quote_q <= 1'b1;
			escape_tags_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				hee_pkg::REG_ESCAPE_QUOTE: escape_quote_q <= cfg_data;
				hee_pkg::REG_ESCAPE_TAGS:  escape_tags_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cp = s_tdata[hee_pkg::CP_W-1:0];

	always_comb begin
		cls_item        = '0;
		cls_item.value  = cp;
		cls_item.ch     = cp[7:0];
		cls_item.kind   = hee_pkg::KIND_PLAIN;
		if (cp > hee_pkg::ASCII_MAX) begin
			cls_item.kind = hee_pkg::KIND_NUM;
		end else if (cp[7:0] == hee_pkg::CH_QUOT && escape_quote_q) begin
			cls_item.kind = hee_pkg::KIND_QUOT;
		end else if (cp[7:0] == hee_pkg::CH_LT && escape_tags_q) begin
			cls_item.kind = hee_pkg::KIND_LT;
		end else if (cp[7:0] == hee_pkg::CH_GT && escape_tags_q) begin
			cls_item.kind = hee_pkg::KIND_GT;
		end else if (cp[7:0] == hee_pkg::CH_AMP) begin
			cls_item.kind = hee_pkg::KIND_AMP;
		end
		if (cp >= 21'd1000000) begin
			cls_item.num_digits = 3'd7;
		end else if (cp >= 21'd100000) begin
			cls_item.num_digits = 3'd6;
		end else if (cp >= 21'd10000) begin
			cls_item.num_digits = 3'd5;
		end else if (cp >= 21'd1000) begin
			cls_item.num_digits = 3'd4;
		end else begin
			cls_item.num_digits = 3'd3;
		end
	end

	// stall chain: a stage loads when empty or when its successor loads
	assign fmt_load = !fmt_valid || emit_take;

	always_comb begin
		dig_load[ND] = !dig_valid[ND] || fmt_load;
		for (int k = ND - 1; k >= 0; k--) begin
			dig_load[k] = !dig_valid[k] || dig_load[k+1];
		end
	end

	assign s_tready = dig_load[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			item_s1 <= cls_item;
		end
	end

	assign dig_valid[0] = valid_s1;
	assign dig_item[0]  = item_s1;

	for (genvar k = 0; k < ND; k++) begin : g_digit
		hee_digit u_digit (
			.clk       (clk),
			.arst_n    (arst_n),
			.load      (dig_load[k+1]),
			.in_valid  (dig_valid[k]),
			.in_item   (dig_item[k]),
			.out_valid (dig_valid[k+1]),
			.out_item  (dig_item[k+1])
		);
	end

	hee_format u_format (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fmt_load),
		.in_valid  (dig_valid[ND]),
		.in_item   (dig_item[ND]),
		.out_valid (fmt_valid),
		.out_text  (fmt_text)
	);

	hee_emitter u_emitter (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fmt_valid),
		.in_text  (fmt_text),
		.take     (emit_take),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

FILE: sv/hee_port_monitor.sv
// ----------------------------------------------------------------------------
// hee_port_monitor
// Port-level checks of the entity encoder output stream.
// ----------------------------------------------------------------------------
`include "html_entity_encoder_unit_assert.svh"

module hee_port_monitor (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [23:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast,
	input logic        cfg_we,
	input logic        cfg_index,
	input logic        cfg_data
);

	// stalled request holds
	`HEE_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
	// escape sequences are pure ASCII
	`HEE_ASSERT_SAME(a_escape_ascii, m_tvalid && !m_tlast, m_tdata[7] == 1'b0)
	// semicolon only closes a sequence
	`HEE_ASSERT_SAME(a_semi_last, m_tvalid && !m_tlast, m_tdata != 8'h3B)
	// a sequence continues without a gap
	`HEE_ASSERT_NEXT(a_no_gap, m_tvalid && m_tready && !m_tlast, m_tvalid)

endmodule

bind html_entity_encoder_unit hee_port_monitor u_port_monitor (.*);

FILE: tb/sv/html_entity_encoder_unit_checker.sv
// ----------------------------------------------------------------------------
// html_entity_encoder_unit_checker
// Watches the input, output and register channels of the entity encoder,
// builds the escaped byte sequence of every accepted code point, and compares
// each accepted output byte and its last flag with the oldest expected byte.
// ----------------------------------------------------------------------------
module html_entity_encoder_unit_checker
	import hee_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,  // [20:0] code_point, [23:21] zero
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,  // [7:0] out_byte
	input  logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic        cfg_data,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0] data;
		logic       is_last;
	} esc_byte_t;

	esc_byte_t  expected_bytes [$];
	logic [7:0] esc_text [$];
	logic       quote_on;
	logic       tags_on;

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			esc_text.push_back(8'(s[i]));
	endfunction

	function automatic void push_escaped_text(logic [CP_W-1:0] cp);
		int unsigned v;
		logic [7:0]  digs [$];
		esc_text.delete();
		if (cp > ASCII_MAX) begin
			v = cp;
			do begin
				digs.push_front(8'(CH_ZERO + v % 10));
				v = v / 10;
			end while (v != 0);
			esc_text.push_back(CH_AMP);
			esc_text.push_back(CH_HASH);
			foreach (digs[i])
				esc_text.push_back(digs[i]);
			esc_text.push_back(CH_SEMI);
		end else if (cp == CH_QUOT && quote_on) begin
			add_text("&quot;");
		end else if (cp == CH_LT && tags_on) begin
			add_text("&lt;");
		end else if (cp == CH_GT && tags_on) begin
			add_text("&gt;");
		end else if (cp == CH_AMP) begin
			add_text("&amp;");
		end else begin
			esc_text.push_back(cp[7:0]);
		end
		foreach (esc_text[i])
			expected_bytes.push_back('{esc_text[i], i == esc_text.size() - 1});
	endfunction

	always @(posedge clk or negedge arst_n) begin
		esc_byte_t exp_b;
		if (!arst_n) begin
			quote_on = 1'b1;
			tags_on = 1'b1;
			fail_count = 0;
			expected_bytes.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_bytes.size() == 0) begin
					$display("%0t: unexpected byte, expected none, actual %02h last %0b",
						$time, m_tdata, m_tlast);
					fail_count++;
				end else begin
					exp_b = expected_bytes.pop_front();
					if (m_tdata !== exp_b.data || m_tlast !== exp_b.is_last) begin
						$display("%0t: byte mismatch, expected %02h last %0b, actual %02h last %0b",
							$time, exp_b.data, exp_b.is_last, m_tdata, m_tlast);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				push_escaped_text(s_tdata[CP_W-1:0]);
			if (cfg_we) begin
				if (cfg_index == REG_ESCAPE_QUOTE)
					quote_on = cfg_data;
				else
					tags_on = cfg_data;
			end
		end
		pending = expected_bytes.size();
	end

endmodule

FILE: tb/sv/tb_html_entity_encoder_unit.sv
// ----------------------------------------------------------------------------
// tb_html_entity_encoder_unit
// Stimulus and verdict for the entity encoder: corner code points under the
// reset settings, then random code points under every register setting, with
// random stalls on both streams, one long output hold-off and full drains.
// ----------------------------------------------------------------------------
module tb_html_entity_encoder_unit;
	import hee_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD      = 300;
	localparam int PIPE_LATENCY   = 12;
	localparam int RAND_PER_PHASE = 73;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // [20:0] code_point, [23:21] zero
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [7:0] out_byte
	logic        m_tlast;
	logic        cfg_we;
	logic        cfg_index;
	logic        cfg_data;

	int          fail_count;
	int          pending;
	int          idle_cycles = 0;
	logic        s_acc = 1'b0;
	bit          idle_en = 1'b1;
	bit          hold_req = 1'b0;

	logic [CP_W-1:0] corner_cps [24] = '{
		21'd0, 21'd1, 21'd9, 21'd65, 21'd126, 21'd127, 21'd128, 21'd129,
		21'd999, 21'd1000, 21'd9999, 21'd10000, 21'd99999, 21'd100000,
		21'd999999, 21'd1000000, 21'd1114111, 21'd1114112, 21'h00D800,
		21'h1FFFFF, 21'(CH_QUOT), 21'(CH_LT), 21'(CH_GT), 21'(CH_AMP)
	};

	html_entity_encoder_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	html_entity_encoder_unit_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		s_acc <= s_tvalid && s_tready;
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [CP_W-1:0] rand_code_point();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return 21'($urandom_range(0, 127));
		else if (r < 55) begin
			case ($urandom_range(0, 3))
				0: return 21'(CH_QUOT);
				1: return 21'(CH_LT);
				2: return 21'(CH_GT);
				default: return 21'(CH_AMP);
			endcase
		end else if (r < 80)
			return 21'($urandom_range(128, 1114111));
		return 21'($urandom());
	endfunction

	// called and returns at a falling edge
	task automatic send_char(logic [CP_W-1:0] cp);
		int g;
		s_tvalid <= 1'b1;
		s_tdata <= {3'b000, cp};
		do @(negedge clk); while (!s_acc);
		g = idle_en ? gap_len() : 0;
		if (g > 0) begin
			s_tvalid <= 1'b0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		wait (pending == 0);
		@(negedge clk);
		repeat (PIPE_LATENCY) @(negedge clk);
	endtask

	task automatic write_regs(logic quote_v, logic tags_v);
		cfg_we <= 1'b1;
		cfg_index <= REG_ESCAPE_QUOTE;
		cfg_data <= quote_v;
		@(negedge clk);
		cfg_index <= REG_ESCAPE_TAGS;
		cfg_data <= tags_v;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// output side: random stalls, plus one long hold-off on request
	initial begin
		int rx_left;
		int hold_left;
		rx_left = 0;
		hold_left = 0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!idle_en) begin
				m_tready <= 1'b1;
			end else if (rx_left > 0) begin
				rx_left--;
			end else if (m_tready) begin
				m_tready <= 1'b0;
				rx_left = gap_len();
			end else begin
				m_tready <= 1'b1;
				rx_left = $urandom_range(0, 15);
			end
		end
	end

	initial begin
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("tb_html_entity_encoder_unit: FAIL");
		$finish;
	end

	initial begin
		logic [1:0] phase_cfg [5];
		phase_cfg = '{2'b00, 2'b10, 2'b01, 2'b11, 2'b00};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = REG_ESCAPE_QUOTE;
		cfg_data = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// corner code points with reset settings
		foreach (corner_cps[i])
			send_char(corner_cps[i]);
		drain();

		for (int ph = 0; ph < 5; ph++) begin
			write_regs(phase_cfg[ph][1], phase_cfg[ph][0]);
			send_char(21'(CH_QUOT));
			send_char(21'(CH_LT));
			send_char(21'(CH_GT));
			send_char(21'(CH_AMP));
			for (int i = 0; i < RAND_PER_PHASE; i++) begin
				idle_en = ((i / 25) % 2) == 0;
				if (ph == 1 && i == 30)
					hold_req = 1'b1;
				if (ph == 2 && i == 40) begin
					s_tvalid <= 1'b0;
					wait (pending == 0);
					@(negedge clk);
				end
				send_char(rand_code_point());
			end
			idle_en = 1'b1;
			drain();
		end

		repeat (2 * PIPE_LATENCY) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_html_entity_encoder_unit: PASS");
		else
			$display("tb_html_entity_encoder_unit: FAIL");
		$finish;
	end

endmodule
